// File: rtl/momt_pkg.sv
// Shared types and constants for the module-to-object mapping table.
`default_nettype none

package momt_pkg;

  // Table size and derived widths
  localparam int SLOTS   = 16;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int STEP_W  = $clog2(SLOTS + 1);
  localparam int MAX_OUT = 16;
  localparam int LIST_W  = $clog2(MAX_OUT + 1);

  // Field widths
  localparam int ACT_W   = 3;
  localparam int MOD_W   = 8;
  localparam int OBJ_W   = 16;
  localparam int SEC_W   = 16;
  localparam int LIM_W   = 8;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [ACT_W-1:0] {
    ACT_FIND_MOD = 3'd0,
    ACT_FIND_OBJ = 3'd1,
    ACT_STORE    = 3'd2,
    ACT_REMOVE   = 3'd3,
    ACT_LIST     = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [MOD_W-1:0] mod_num;
    logic [OBJ_W-1:0] obj_num;
    logic [SEC_W-1:0] sectors;
  } entry_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [MOD_W-1:0] mod_num;
    logic [OBJ_W-1:0] obj_num;
    logic [SEC_W-1:0] sectors;
    logic [LIM_W-1:0] limit;
  } request_t;

  typedef struct packed {
    status_t            status;
    entry_t             ent;
    logic [COUNT_W-1:0] count;
    logic               last;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic adv;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic stall;
    logic scan_end;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/momt_ctrl.sv
// Sequencing state machine: accept, slot scan, finish.
`default_nettype none

module momt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire momt_pkg::sts_t sts,
  output momt_pkg::cmd_t      cmd
);
  import momt_pkg::*;

  state_t state;
  state_t state_next;

  // Hold the current state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pick the next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!sts.stall && sts.scan_end) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Drive commands to the datapath
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      S_SCAN: begin
        cmd.adv = !sts.stall;
      end
      S_FINISH: begin
        cmd.finish = !sts.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/momt_dp.sv
// Datapath: slot memory, valid marks, scan compare, finish update, result register.
`default_nettype none

module momt_dp (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire momt_pkg::request_t           in_req,
  input  wire momt_pkg::cmd_t               cmd,
  output momt_pkg::sts_t                    sts,
  output momt_pkg::result_t                 out_res,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [momt_pkg::SLOTS-1:0]        valid_vec,
  output logic [momt_pkg::COUNT_W-1:0]      valid_count
);
  import momt_pkg::*;

  // Slot storage
  entry_t mem [SLOTS];
  entry_t mem_q;

  logic [SLOTS-1:0]   slot_valid;
  logic [COUNT_W-1:0] count;
  request_t           req;
  logic [STEP_W-1:0]  step;
  logic               q_vld;
  logic [IDX_W-1:0]   q_idx;
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  entry_t             hit_ent;
  logic [LIST_W-1:0]  list_n;

  logic [LIST_W-1:0]  limit_eff;
  logic               key_match;
  logic               slot_live;
  logic               list_emit;
  logic               out_busy;
  logic [SLOTS-1:0]   above;
  logic               more_valid;
  logic               list_last;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  result_t            list_res;
  result_t            fin_res;
  logic               fin_emit;
  logic               fin_write;
  logic [IDX_W-1:0]   fin_idx;
  entry_t             fin_ent;
  logic               fin_set;
  logic               fin_clr;
  logic               out_load;

  // Clamp the list length
  assign limit_eff = (req.limit > LIM_W'(MAX_OUT)) ? LIST_W'(MAX_OUT)
                                                   : LIST_W'(req.limit);

  // Compare the entry read at the previous scan step against the key
  assign key_match = (req.action == ACT_FIND_OBJ) ? (mem_q.obj_num == req.obj_num)
                                                  : (mem_q.mod_num == req.mod_num);
  assign slot_live = q_vld && slot_valid[q_idx];
  assign list_emit = (req.action == ACT_LIST) && slot_live && (list_n < limit_eff);
  assign out_busy  = out_valid && !out_ready;

  assign sts.stall    = list_emit && out_busy;
  assign sts.scan_end = (step == STEP_W'(SLOTS));
  assign sts.out_busy = out_busy;

  // Find whether any valid slot follows the one under compare
  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      above[j] = (IDX_W'(j) > q_idx);
    end
  end
  assign more_valid = |(slot_valid & above);
  assign list_last  = (LIST_W'(list_n + LIST_W'(1)) == limit_eff) || !more_valid;

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (!slot_valid[j]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(j);
      end
    end
  end

  // Result for one listed module
  always_comb begin
    list_res             = '0;
    list_res.status      = ST_OK;
    list_res.ent.mod_num = mem_q.mod_num;
    list_res.count       = count;
    list_res.last        = list_last;
  end

  // Decide the closing update and result of the request
  always_comb begin
    fin_res        = '0;
    fin_res.status = ST_MISS;
    fin_res.count  = count;
    fin_res.last   = 1'b1;
    fin_emit       = 1'b1;
    fin_write      = 1'b0;
    fin_idx        = hit_idx;
    fin_ent        = hit_ent;
    fin_set        = 1'b0;
    fin_clr        = 1'b0;
    unique case (req.action) inside
      ACT_FIND_MOD, ACT_FIND_OBJ: begin
        if (hit) begin
          fin_res.status = ST_OK;
          fin_res.ent    = hit_ent;
        end
      end
      ACT_STORE: begin
        if (hit) begin
          fin_write      = 1'b1;
          fin_ent        = '{mod_num: hit_ent.mod_num, obj_num: hit_ent.obj_num,
                             sectors: req.sectors};
          fin_res.status = ST_OK;
          fin_res.ent    = fin_ent;
        end else if (free_found) begin
          fin_write      = 1'b1;
          fin_set        = 1'b1;
          fin_idx        = free_idx;
          fin_ent        = '{mod_num: req.mod_num, obj_num: req.obj_num,
                             sectors: req.sectors};
          fin_res.status = ST_OK;
          fin_res.ent    = fin_ent;
          fin_res.count  = COUNT_W'(count + COUNT_W'(1));
        end else begin
          fin_res.status = ST_FULL;
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          fin_clr        = 1'b1;
          fin_res.status = ST_OK;
          fin_res.ent    = hit_ent;
          fin_res.count  = COUNT_W'(count - COUNT_W'(1));
        end
      end
      ACT_LIST: begin
        fin_emit = (list_n == '0);
      end
      default: begin
        fin_emit = 1'b1;
      end
    endcase
  end

  // Write at finish, read one slot per scan step
  always_ff @(posedge clk) begin
    if (cmd.finish && fin_write) begin
      mem[fin_idx] <= fin_ent;
    end
    if (cmd.adv) begin
      mem_q <= mem[step[IDX_W-1:0]];
    end
  end

  // Capture the request and the scan payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req <= in_req;
    end
    if (cmd.adv) begin
      q_idx <= step[IDX_W-1:0];
      if (slot_live && key_match && !hit) begin
        hit_idx <= q_idx;
        hit_ent <= mem_q;
      end
    end
  end

  // Advance the scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= '0;
      q_vld  <= 1'b0;
      hit    <= 1'b0;
      list_n <= '0;
    end else if (cmd.start) begin
      step   <= '0;
      q_vld  <= 1'b0;
      hit    <= 1'b0;
      list_n <= '0;
    end else if (cmd.adv) begin
      step  <= STEP_W'(step + STEP_W'(1));
      q_vld <= !sts.scan_end;
      if (slot_live && key_match) hit <= 1'b1;
      if (list_emit) list_n <= LIST_W'(list_n + LIST_W'(1));
    end
  end

  // Update valid marks and the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      count      <= '0;
    end else if (cmd.finish) begin
      if (fin_set) slot_valid[fin_idx] <= 1'b1;
      if (fin_clr) slot_valid[fin_idx] <= 1'b0;
      count <= fin_res.count;
    end
  end

  // Result register
  assign out_load = (cmd.adv && list_emit) || (cmd.finish && fin_emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= (cmd.adv && list_emit) ? list_res : fin_res;
    end
  end

  assign valid_vec   = slot_valid;
  assign valid_count = count;

endmodule

`default_nettype wire

// File: rtl/module_object_mapping_table.sv
// Module-to-object mapping table top level: stream ports, controller and datapath.
//
// Usage: one request on the slave side carries one action (find by module,
// find by object, store, remove, list) in s_tuser and its operands in s_tdata.
// Each request produces one result on the master side, or for list one result
// per listed module number; m_tlast marks the final result of a request and
// m_tuser carries its status (ok, not found or empty, table full).
// Flow: a request is accepted, then the slot memory is scanned one slot per
// cycle through a registered read port (while the scan is not stalled), then
// the finish state updates the table and loads the closing result. s_tready
// is high only between requests.
// A result register sits between the scan and the master side: when the
// receiver holds m_tready low, a list scan pauses at its next emitted module
// and the finish cycle waits until the register is free.
// Reset clears all valid marks and the entry count; no clearing pass is needed.
`default_nettype none

module module_object_mapping_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata: module_number[7:0], object_number[23:8], sectors_used[39:24],
  //          list_limit[47:40]
  input  wire logic [47:0] s_tdata,
  // s_tuser: action[2:0]
  input  wire logic [2:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata: hit_module[7:0], hit_object[23:8], hit_sectors[39:24],
  //          entries_in_use[44:40], zero[47:45]
  output logic [47:0]      m_tdata,
  // m_tuser: status[1:0]
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);
  import momt_pkg::*;

  request_t           in_req;
  result_t            out_res;
  cmd_t               cmd;
  sts_t               sts;
  logic [SLOTS-1:0]   valid_vec;
  logic [COUNT_W-1:0] valid_count;

  // Unpack the request
  assign in_req.action  = s_tuser;
  assign in_req.mod_num = s_tdata[7:0];
  assign in_req.obj_num = s_tdata[23:8];
  assign in_req.sectors = s_tdata[39:24];
  assign in_req.limit   = s_tdata[47:40];

  momt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  momt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_req      (in_req),
    .cmd         (cmd),
    .sts         (sts),
    .out_res     (out_res),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .valid_vec   (valid_vec),
    .valid_count (valid_count)
  );

  // Pack the result
  assign m_tdata = {3'b000, out_res.count, out_res.ent.sectors,
                    out_res.ent.obj_num, out_res.ent.mod_num};
  assign m_tuser = out_res.status;
  assign m_tlast = out_res.last;

  // Entry count tracks the valid marks
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    valid_count == COUNT_W'($countones(valid_vec)))
    else $error("entry count differs from number of valid slots");

  // A full report only comes from a completely filled table
  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == ST_FULL)) |-> (m_tdata[44:40] == COUNT_W'(SLOTS)))
    else $error("table full reported with free slots");

  // A request is followed by its scan, never by another request
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted during scan");

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the module-to-object mapping table.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import momt_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNUSED_LAST  = 3'd7;
  localparam int RANDOM_REQUESTS = 212;
  localparam int QUIET_TAIL      = 40;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int MAX_REPORTS     = 10;

  // Track table contents and the results each accepted request must produce
  class table_scoreboard;
    bit                 occupied[SLOTS];
    logic [MOD_W-1:0]   slot_mod[SLOTS];
    logic [OBJ_W-1:0]   slot_obj[SLOTS];
    logic [SEC_W-1:0]   slot_sec[SLOTS];
    logic [COUNT_W-1:0] in_use;
    result_t            expected_q[$];
    int                 errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        occupied[i] = 1'b0;
        slot_mod[i] = '0;
        slot_obj[i] = '0;
        slot_sec[i] = '0;
      end
      in_use = '0;
      errors = 0;
    endfunction

    function void push_result(status_t st, logic [MOD_W-1:0] m, logic [OBJ_W-1:0] o,
                              logic [SEC_W-1:0] s, logic l);
      result_t r;
      r.status      = st;
      r.ent.mod_num = m;
      r.ent.obj_num = o;
      r.ent.sectors = s;
      r.count       = in_use;
      r.last        = l;
      expected_q.push_back(r);
    endfunction

    function int slot_of_module(logic [MOD_W-1:0] m);
      for (int i = 0; i < SLOTS; i++)
        if (occupied[i] && slot_mod[i] == m) return i;
      return -1;
    endfunction

    function int slot_of_object(logic [OBJ_W-1:0] o);
      for (int i = 0; i < SLOTS; i++)
        if (occupied[i] && slot_obj[i] == o) return i;
      return -1;
    endfunction

    // Apply one accepted request to the table and queue its results
    function void note_request(logic [ACT_W-1:0] act, logic [MOD_W-1:0] m,
                               logic [OBJ_W-1:0] o, logic [SEC_W-1:0] s,
                               logic [LIM_W-1:0] lim);
      int slot;
      int emitted;
      int cap;
      case (act)
        ACT_FIND_MOD, ACT_FIND_OBJ: begin
          slot = (act == ACT_FIND_MOD) ? slot_of_module(m) : slot_of_object(o);
          if (slot < 0) push_result(ST_MISS, '0, '0, '0, 1'b1);
          else push_result(ST_OK, slot_mod[slot], slot_obj[slot], slot_sec[slot], 1'b1);
        end
        ACT_STORE: begin
          slot = slot_of_module(m);
          if (slot < 0) begin
            for (int i = SLOTS - 1; i >= 0; i--)
              if (!occupied[i]) slot = i;
            if (slot >= 0) begin
              occupied[slot] = 1'b1;
              slot_mod[slot] = m;
              slot_obj[slot] = o;
              in_use = in_use + 1'b1;
            end
          end
          if (slot < 0) begin
            push_result(ST_FULL, '0, '0, '0, 1'b1);
          end else begin
            slot_sec[slot] = s;
            push_result(ST_OK, slot_mod[slot], slot_obj[slot], slot_sec[slot], 1'b1);
          end
        end
        ACT_REMOVE: begin
          slot = slot_of_module(m);
          if (slot < 0) begin
            push_result(ST_MISS, '0, '0, '0, 1'b1);
          end else begin
            // Count in the result already reflects the removal
            occupied[slot] = 1'b0;
            in_use = in_use - 1'b1;
            push_result(ST_OK, slot_mod[slot], slot_obj[slot], slot_sec[slot], 1'b1);
            slot_mod[slot] = '0;
            slot_obj[slot] = '0;
            slot_sec[slot] = '0;
          end
        end
        ACT_LIST: begin
          cap = (lim > MAX_OUT) ? MAX_OUT : int'(lim);
          emitted = 0;
          for (int i = 0; i < SLOTS; i++)
            if (occupied[i] && emitted < cap) begin
              push_result(ST_OK, slot_mod[i], '0, '0, 1'b0);
              emitted++;
            end
          if (emitted == 0) push_result(ST_MISS, '0, '0, '0, 1'b1);
          else expected_q[expected_q.size() - 1].last = 1'b1;
        end
        default: push_result(ST_MISS, '0, '0, '0, 1'b1);
      endcase
    endfunction

    // Compare one accepted result against the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: status=%0d mod=%h obj=%h sec=%h count=%0d last=%b",
                   got.status, got.ent.mod_num, got.ent.obj_num, got.ent.sectors,
                   got.count, got.last);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $write("mismatch: expected status=%0d mod=%h obj=%h sec=%h count=%0d last=%b",
                 want.status, want.ent.mod_num, want.ent.obj_num, want.ent.sectors,
                 want.count, want.last);
          $display(" got status=%0d mod=%h obj=%h sec=%h count=%0d last=%b",
                   got.status, got.ent.mod_num, got.ent.obj_num, got.ent.sectors,
                   got.count, got.last);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  table_scoreboard  sb = new();
  bit               quiet;
  int               cycles;
  logic [MOD_W-1:0] mod_pool[24];

  module_object_mapping_table u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Check every result taken by the receiver
  always @(posedge clk) begin
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status      = status_t'(m_tuser);
      got.ent.mod_num = m_tdata[7:0];
      got.ent.obj_num = m_tdata[23:8];
      got.ent.sectors = m_tdata[39:24];
      got.count       = m_tdata[44:40];
      got.last        = m_tlast;
      sb.check_result(got);
    end
  end

  // Stall the result side in random bursts until the quiet tail
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  // Present one request and hold it until accepted
  task automatic send_request(logic [ACT_W-1:0] act, logic [MOD_W-1:0] m,
                              logic [OBJ_W-1:0] o, logic [SEC_W-1:0] s,
                              logic [LIM_W-1:0] lim);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {lim, s, o, m};
    do @(posedge clk); while (!s_tready);
    sb.note_request(act, m, o, s, lim);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [MOD_W-1:0] pick_module();
    if ($urandom_range(0, 4) != 0) return mod_pool[$urandom_range(0, 23)];
    return MOD_W'($urandom_range(0, 255));
  endfunction

  // Mostly an object that is in the table, so object lookups hit
  function automatic logic [OBJ_W-1:0] pick_lookup_object();
    int start;
    start = $urandom_range(0, SLOTS - 1);
    if ($urandom_range(0, 9) < 7)
      for (int k = 0; k < SLOTS; k++)
        if (sb.occupied[(start + k) % SLOTS]) return sb.slot_obj[(start + k) % SLOTS];
    return OBJ_W'($urandom_range(0, 65535));
  endfunction

  // Reuse a few object numbers so duplicate objects appear in the table
  function automatic logic [OBJ_W-1:0] pick_store_object();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'h0042;
      default: return OBJ_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [LIM_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0:             return '0;
      1:             return 8'hff;
      2, 3, 4, 5, 6: return LIM_W'($urandom_range(1, 17));
      default:       return LIM_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Weight actions by phase: fill the table, drain it, then mix
  function automatic logic [ACT_W-1:0] pick_action(int n);
    int r;
    r = $urandom_range(0, 99);
    if (n < 80) begin
      if (r < 55) return ACT_STORE;
      if (r < 67) return ACT_FIND_MOD;
      if (r < 77) return ACT_FIND_OBJ;
      if (r < 85) return ACT_REMOVE;
      if (r < 97) return ACT_LIST;
    end else if (n < 150) begin
      if (r < 20) return ACT_STORE;
      if (r < 60) return ACT_REMOVE;
      if (r < 70) return ACT_FIND_MOD;
      if (r < 80) return ACT_FIND_OBJ;
      if (r < 95) return ACT_LIST;
    end else begin
      if (r < 35) return ACT_STORE;
      if (r < 60) return ACT_REMOVE;
      if (r < 70) return ACT_FIND_MOD;
      if (r < 80) return ACT_FIND_OBJ;
      if (r < 97) return ACT_LIST;
    end
    return ACT_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
  endfunction

  initial begin
    logic [ACT_W-1:0] act;
    logic [OBJ_W-1:0] obj;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    quiet    = 1'b0;
    cycles   = 0;
    mod_pool[0] = 8'h00;
    mod_pool[1] = 8'hff;
    for (int i = 2; i < 24; i++) mod_pool[i] = MOD_W'($urandom_range(1, 254));
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty table: list, lookups and remove all miss
    send_request(ACT_LIST,     8'h00, 16'h0000, 16'h0000, 8'd5);
    send_request(ACT_FIND_MOD, 8'h00, 16'h0000, 16'h0000, 8'h00);
    send_request(ACT_FIND_OBJ, 8'hff, 16'hffff, 16'hffff, 8'hff);
    send_request(ACT_REMOVE,   8'h12, 16'h3456, 16'h789a, 8'h01);
    // Unused action codes are ignored
    for (int k = ACT_UNUSED_FIRST; k <= ACT_UNUSED_LAST; k++)
      send_request(ACT_W'(k), 8'hff, 16'hffff, 16'hffff, 8'hff);
    // New entries at the field extremes, then an update of an existing one
    send_request(ACT_STORE,    8'h00, 16'h0000, 16'h0000, 8'h00);
    send_request(ACT_STORE,    8'hff, 16'hffff, 16'hffff, 8'hff);
    send_request(ACT_STORE,    8'hff, 16'h0000, 16'h1234, 8'h00);
    send_request(ACT_FIND_MOD, 8'hff, 16'h0000, 16'h0000, 8'h00);
    send_request(ACT_FIND_OBJ, 8'h00, 16'hffff, 16'h0000, 8'h00);
    // List with a zero limit, a huge limit and a limit of one
    send_request(ACT_LIST,     8'h00, 16'h0000, 16'h0000, 8'h00);
    send_request(ACT_LIST,     8'h00, 16'h0000, 16'h0000, 8'hff);
    send_request(ACT_LIST,     8'h00, 16'h0000, 16'h0000, 8'h01);
    // Removing slot zero makes it the lowest free slot again
    send_request(ACT_REMOVE,   8'h00, 16'h0000, 16'h0000, 8'h00);
    send_request(ACT_FIND_MOD, 8'h00, 16'h0000, 16'h0000, 8'h00);
    send_request(ACT_STORE,    8'h07, 16'h0777, 16'h0070, 8'h00);
    send_request(ACT_LIST,     8'h00, 16'h0000, 16'h0000, 8'h10);

    // Hold off until every outstanding result has been taken
    s_tvalid <= 1'b0;
    wait_drained();

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == RANDOM_REQUESTS - QUIET_TAIL) quiet = 1'b1;
      act = pick_action(n);
      obj = (act == ACT_FIND_OBJ) ? pick_lookup_object() : pick_store_object();
      send_request(act, pick_module(), obj, SEC_W'($urandom_range(0, 65535)), pick_limit());
    end
    s_tvalid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
